>>> src/wspc_pkg.sv
// Shared constants and types for the wall segment projection and clip block.
`timescale 1ns / 1ps
`default_nettype none

package wspc_pkg;

  // Fixed point layout of the trig terms and the saturation bound of view coordinates
  localparam int TRIG_BITS      = 28;
  localparam int T_MAX          = (2 ** 30) - 1;
  localparam int MAX_VIEW_WIDTH = 4096;

  // Divider geometry: dividend, divisor magnitude and quotient widths
  localparam int DVD_W = 63;
  localparam int DSR_W = 34;
  localparam int QUO_W = 32;

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_SIN     = 3'd0,
    REG_VIEW_COS     = 3'd1,
    REG_VIEW_TAN_COS = 3'd2,
    REG_VIEW_TAN_SIN = 3'd3,
    REG_CENTER_X     = 3'd4,
    REG_VIEW_WIDTH   = 3'd5,
    REG_MIRROR_X     = 3'd6,
    REG_NEAR_LIMIT   = 3'd7
  } cfg_reg_e;

  // Per-transaction data that travels beside the dividers
  typedef struct packed {
    logic signed [31:0] ly;
    logic signed [31:0] ry;
    logic               in_l;
    logic               in_r;
    logic               rej_l;
    logic               rej_r;
    logic               neg_l;
    logic               neg_r;
    logic signed [47:0] uoz_org;
    logic signed [31:0] uoz_stp;
    logic signed [47:0] iz_org;
    logic signed [31:0] iz_stp;
  } side_t;

endpackage

`default_nettype wire

>>> src/wall_segment_project_clip_top.sv
// Top level: wall segment view transform, wedge clip and screen projection.
//
// Usage: segments enter on the in channel (in_valid_i / in_stall_o) with both endpoints
// relative to the viewer in Q16.16. One result per segment leaves on the out channel
// (out_valid_o / out_stall_i), in order. A transaction moves at a clock edge with valid
// high and stall low. View terms are written on the cfg channel (cfg_valid_i,
// cfg_ready_o always high) while no segment is in flight.
// Throughput: one segment per cycle unless out_stall_i holds a waiting result.
// The depth is set by the two 32-stage restoring dividers (one quotient bit per stage)
// that form the screen column or the clipped depth of each edge, plus three stages
// ahead (multiply, sum, clip setup), one divider load stage and two finishing stages.
// Reset: in-flight transactions are dropped, config registers return to an unrotated
// view, 320 columns centered at 160, no mirroring, no near limit.
// Stall: while out_stall_i holds a waiting result, the whole pipeline freezes and
// in_stall_o rises; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module wall_segment_project_clip_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wspc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [31:0]                 left_x_i,
  input  logic signed [31:0]                 left_y_i,
  input  logic signed [31:0]                 right_x_i,
  input  logic signed [31:0]                 right_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               rejected_o,
  output logic [12:0]                        screen_left_o,
  output logic [12:0]                        screen_right_o,
  output logic signed [31:0]                 depth_left_o,
  output logic signed [31:0]                 depth_right_o,
  output logic signed [47:0]                 u_over_z_origin_o,
  output logic signed [31:0]                 u_over_z_step_o,
  output logic signed [47:0]                 inv_z_origin_o,
  output logic signed [31:0]                 inv_z_step_o
);

  localparam int DIV_LAT = wspc_pkg::QUO_W + 1;
  localparam int NSTG    = DIV_LAT + 5;

  // ---------------------------------------------------------------- config
  logic signed [31:0] view_sin_q, view_cos_q, view_tan_cos_q, view_tan_sin_q;
  logic [11:0]        center_x_q;
  logic [12:0]        view_width_q;
  logic               mirror_x_q;
  logic [30:0]        near_limit_q;
  logic [12:0]        vw;
  logic signed [32:0] cxs;

  assign cfg_ready_o = 1'b1;

  // Write one register per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_sin_q     <= '0;
      view_cos_q     <= 32'sh1000_0000;
      view_tan_cos_q <= 32'sh1000_0000;
      view_tan_sin_q <= '0;
      center_x_q     <= 12'd160;
      view_width_q   <= 13'd320;
      mirror_x_q     <= 1'b0;
      near_limit_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (wspc_pkg::cfg_reg_e'(cfg_index_i))
        wspc_pkg::REG_VIEW_SIN:     view_sin_q     <= cfg_data_i;
        wspc_pkg::REG_VIEW_COS:     view_cos_q     <= cfg_data_i;
        wspc_pkg::REG_VIEW_TAN_COS: view_tan_cos_q <= cfg_data_i;
        wspc_pkg::REG_VIEW_TAN_SIN: view_tan_sin_q <= cfg_data_i;
        wspc_pkg::REG_CENTER_X:     center_x_q     <= cfg_data_i[11:0];
        wspc_pkg::REG_VIEW_WIDTH:   view_width_q   <= cfg_data_i[12:0];
        wspc_pkg::REG_MIRROR_X:     mirror_x_q     <= cfg_data_i[0];
        wspc_pkg::REG_NEAR_LIMIT:   near_limit_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Clamp the view width to the supported maximum
  assign vw  = ({19'b0, view_width_q} > 32'(wspc_pkg::MAX_VIEW_WIDTH))
               ? 13'(wspc_pkg::MAX_VIEW_WIDTH) : view_width_q;
  assign cxs = $signed({21'b0, center_x_q});

  // ---------------------------------------------------------------- flow control
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NSTG-1];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic signed [63:0] p_axs_q, p_ayc_q, p_axt_q, p_ayt_q;
  logic signed [63:0] p_bxs_q, p_byc_q, p_bxt_q, p_byt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_axs_q <= 64'(left_x_i) * 64'(view_sin_q);
      p_ayc_q <= 64'(left_y_i) * 64'(view_cos_q);
      p_axt_q <= 64'(left_x_i) * 64'(view_tan_cos_q);
      p_ayt_q <= 64'(left_y_i) * 64'(view_tan_sin_q);
      p_bxs_q <= 64'(right_x_i) * 64'(view_sin_q);
      p_byc_q <= 64'(right_y_i) * 64'(view_cos_q);
      p_bxt_q <= 64'(right_x_i) * 64'(view_tan_cos_q);
      p_byt_q <= 64'(right_y_i) * 64'(view_tan_sin_q);
    end
  end

  // ---------------------------------------------------------------- stage 2: sum, mirror
  function automatic logic signed [31:0] fix_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic sub);
    logic signed [64:0] s;
    logic signed [36:0] h;
    logic signed [36:0] hi;
    s  = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    h  = $signed(s[64:wspc_pkg::TRIG_BITS]);
    hi = 37'(wspc_pkg::T_MAX);
    if (h > hi) begin
      h = hi;
    end else if (h < -hi) begin
      h = -hi;
    end
    return 32'(h);
  endfunction

  logic signed [31:0] ax_t, ay_t, bx_t, by_t;
  logic signed [31:0] lx_q, ly_q, rx_q, ry_q;

  assign ax_t = fix_sum(p_axs_q, p_ayc_q, 1'b1);
  assign ay_t = fix_sum(p_axt_q, p_ayt_q, 1'b0);
  assign bx_t = fix_sum(p_bxs_q, p_byc_q, 1'b1);
  assign by_t = fix_sum(p_bxt_q, p_byt_q, 1'b0);

  // Mirror: negate x and swap the endpoints
  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_q <= mirror_x_q ? -bx_t : ax_t;
      ly_q <= mirror_x_q ? by_t  : ay_t;
      rx_q <= mirror_x_q ? -ax_t : bx_t;
      ry_q <= mirror_x_q ? ay_t  : by_t;
    end
  end

  // ---------------------------------------------------------------- stage 3: clip setup
  logic signed [32:0] sl, dl, sr, dr, dyr, ml_a, mr_a, mr_b, dux;
  logic               in_l, in_r, rej_l, rej_r;
  logic signed [31:0] ulx, uly, urx, ury;

  assign sl   = 33'(lx_q) + 33'(ly_q);
  assign dl   = 33'(lx_q) - 33'(ly_q);
  assign sr   = 33'(rx_q) + 33'(ry_q);
  assign dr   = 33'(rx_q) - 33'(ry_q);
  assign dyr  = 33'(ry_q) - 33'(ly_q);
  assign in_l = !sl[32];
  assign in_r = dr[32] || (dr == '0);
  assign rej_l = in_l ? ((lx_q > ly_q) || (ly_q == '0)) : sr[32];
  assign rej_r = in_r ? (sr[32] || (ry_q == '0)) : (lx_q > ly_q);

  // Column numerator or crossing product share one multiplier per edge
  assign ml_a = in_l ? cxs : dyr;
  assign mr_a = in_r ? cxs : dyr;
  assign mr_b = in_r ? sr : dl;

  // Texture terms use the unmirrored order
  assign ulx = mirror_x_q ? rx_q : lx_q;
  assign uly = mirror_x_q ? ry_q : ly_q;
  assign urx = mirror_x_q ? lx_q : rx_q;
  assign ury = mirror_x_q ? ly_q : ry_q;
  assign dux = 33'(ulx) - 33'(urx);

  logic signed [65:0] prod_l_q, prod_r_q;
  logic signed [33:0] den_l_q, den_r_q;
  logic               in_l_q, in_r_q, rej_l_q, rej_r_q;
  logic signed [31:0] ly3_q, ry3_q;
  logic signed [47:0] uoz_org_q, iz_org_q;
  logic signed [31:0] uoz_stp_q, iz_stp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_l_q  <= 66'(ml_a) * 66'(sl);
      prod_r_q  <= 66'(mr_a) * 66'(mr_b);
      den_l_q   <= 34'(sl) - 34'(sr);
      den_r_q   <= 34'(dl) - 34'(dr);
      in_l_q    <= in_l;
      in_r_q    <= in_r;
      rej_l_q   <= rej_l;
      rej_r_q   <= rej_r;
      ly3_q     <= ly_q;
      ry3_q     <= ry_q;
      uoz_org_q <= 48'(ulx) * 48'(cxs);
      uoz_stp_q <= -uly;
      iz_org_q  <= 48'(dux) * 48'(cxs);
      iz_stp_q  <= ury - uly;
    end
  end

  // ---------------------------------------------------------------- stage 4: divider operands
  logic signed [65:0]          col_l, col_r, abs_pl, abs_pr;
  logic signed [33:0]          abs_dl, abs_dr;
  logic [wspc_pkg::DVD_W-1:0]  dvd_l, dvd_r;
  logic [wspc_pkg::DSR_W-1:0]  dsr_l, dsr_r;
  wspc_pkg::side_t             side_d;

  assign col_l  = (prod_l_q <<< 1) + 66'(ly3_q);
  assign col_r  = (prod_r_q <<< 1) + 66'(ry3_q);
  assign abs_pl = prod_l_q[65] ? -prod_l_q : prod_l_q;
  assign abs_pr = prod_r_q[65] ? -prod_r_q : prod_r_q;
  assign abs_dl = den_l_q[33] ? -den_l_q : den_l_q;
  assign abs_dr = den_r_q[33] ? -den_r_q : den_r_q;

  // Column: (2*num + ty) / (2*ty); crossing: |product| / |denominator|
  assign dvd_l = in_l_q ? col_l[wspc_pkg::DVD_W-1:0] : abs_pl[wspc_pkg::DVD_W-1:0];
  assign dvd_r = in_r_q ? col_r[wspc_pkg::DVD_W-1:0] : abs_pr[wspc_pkg::DVD_W-1:0];
  assign dsr_l = in_l_q ? {1'b0, ly3_q, 1'b0} : abs_dl;
  assign dsr_r = in_r_q ? {1'b0, ry3_q, 1'b0} : abs_dr;

  always_comb begin
    side_d         = '0;
    side_d.ly      = ly3_q;
    side_d.ry      = ry3_q;
    side_d.in_l    = in_l_q;
    side_d.in_r    = in_r_q;
    side_d.rej_l   = rej_l_q;
    side_d.rej_r   = rej_r_q;
    side_d.neg_l   = prod_l_q[65] ^ den_l_q[33];
    side_d.neg_r   = prod_r_q[65] ^ den_r_q[33];
    side_d.uoz_org = uoz_org_q;
    side_d.uoz_stp = uoz_stp_q;
    side_d.iz_org  = iz_org_q;
    side_d.iz_stp  = iz_stp_q;
  end

  logic [wspc_pkg::QUO_W-1:0] quo_l, quo_r;

  wspc_div u_div_l (
    .clk_i (clk_i),
    .en_i  (en),
    .dvd_i (dvd_l),
    .dsr_i (dsr_l),
    .quo_o (quo_l)
  );

  wspc_div u_div_r (
    .clk_i (clk_i),
    .en_i  (en),
    .dvd_i (dvd_r),
    .dsr_i (dsr_r),
    .quo_o (quo_r)
  );

  // Carry side data alongside the divider stages
  wspc_pkg::side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- finish 1: edges
  function automatic logic [12:0] clamp_col(input logic [31:0] q, input logic [12:0] w);
    return (q > {19'b0, w}) ? w : q[12:0];
  endfunction

  wspc_pkg::side_t    ds;
  logic signed [33:0] ql_s, qr_s, sgn_l, sgn_r;
  logic signed [34:0] sz1_q, sz2_q;
  logic [12:0]        sx1_q, sx2_q;
  wspc_pkg::side_t    f1_q;

  assign ds    = side_q[DIV_LAT-1];
  assign ql_s  = $signed({2'b00, quo_l});
  assign qr_s  = $signed({2'b00, quo_r});
  assign sgn_l = ds.neg_l ? -ql_s : ql_s;
  assign sgn_r = ds.neg_r ? -qr_s : qr_s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx1_q <= ds.in_l ? clamp_col(quo_l, vw) : 13'd0;
      sx2_q <= ds.in_r ? clamp_col(quo_r, vw) : vw;
      sz1_q <= ds.in_l ? 35'(ds.ly) : (35'(ds.ly) + 35'(sgn_l));
      sz2_q <= ds.in_r ? 35'(ds.ry) : (35'(ds.ly) + 35'(sgn_r));
      f1_q  <= ds;
    end
  end

  // ---------------------------------------------------------------- finish 2: reject, output
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [34:0] near_s;
  logic               rej;

  assign near_s = $signed({4'b0, near_limit_q});
  assign rej    = f1_q.rej_l || f1_q.rej_r || (sz1_q < near_s) || (sz2_q < near_s) ||
                  (sx2_q <= sx1_q);

  // Drop every field of a rejected wall
  always_ff @(posedge clk_i) begin
    if (en) begin
      rejected_o        <= rej;
      screen_left_o     <= rej ? '0 : sx1_q;
      screen_right_o    <= rej ? '0 : sx2_q;
      depth_left_o      <= rej ? '0 : sat32(sz1_q);
      depth_right_o     <= rej ? '0 : sat32(sz2_q);
      u_over_z_origin_o <= rej ? '0 : f1_q.uoz_org;
      u_over_z_step_o   <= rej ? '0 : f1_q.uoz_stp;
      inv_z_origin_o    <= rej ? '0 : f1_q.iz_org;
      inv_z_step_o      <= rej ? '0 : f1_q.iz_stp;
    end
  end

`ifndef NO_ASSERTIONS
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> screen_left_o == '0 && screen_right_o == '0 &&
      depth_left_o == '0 && depth_right_o == '0 && inv_z_step_o == '0)
    else $error("rejected wall carries nonzero fields");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rejected_o |-> screen_right_o > screen_left_o && screen_right_o <= vw)
    else $error("visible wall has empty or out of range column span");

  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rejected_o |-> depth_left_o >= $signed({1'b0, near_limit_q}) &&
      depth_right_o >= $signed({1'b0, near_limit_q}))
    else $error("visible wall nearer than near limit");
`endif

endmodule

`default_nettype wire

>>> src/wspc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module wspc_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [wspc_pkg::DVD_W-1:0]  dvd_i,
  input  logic [wspc_pkg::DSR_W-1:0]  dsr_i,
  output logic [wspc_pkg::QUO_W-1:0]  quo_o
);

  localparam int NST  = wspc_pkg::QUO_W;
  localparam int HI_W = wspc_pkg::DVD_W - wspc_pkg::QUO_W;
  localparam int PAD  = wspc_pkg::DSR_W - HI_W;

  logic [wspc_pkg::DSR_W-1:0] rem_q [NST+1];
  logic [wspc_pkg::QUO_W-1:0] low_q [NST+1];
  logic [wspc_pkg::DSR_W-1:0] dsr_q [NST+1];
  logic [wspc_pkg::DSR_W-1:0] rem_d [NST];
  logic [wspc_pkg::QUO_W-1:0] low_d [NST];

  // One trial subtraction per stage; quotient bits shift in as dividend bits shift out
  for (genvar k = 0; k < NST; k++) begin : g_step
    logic [wspc_pkg::DSR_W:0] trial;
    logic [wspc_pkg::DSR_W:0] diff;
    logic                     ge;
    assign trial    = {rem_q[k], low_q[k][wspc_pkg::QUO_W-1]};
    assign diff     = trial - {1'b0, dsr_q[k]};
    assign ge       = (trial >= {1'b0, dsr_q[k]});
    assign rem_d[k] = ge ? diff[wspc_pkg::DSR_W-1:0] : trial[wspc_pkg::DSR_W-1:0];
    assign low_d[k] = {low_q[k][wspc_pkg::QUO_W-2:0], ge};
  end

  // Load the high dividend part as partial remainder, then advance all stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{PAD{1'b0}}, dvd_i[wspc_pkg::DVD_W-1:wspc_pkg::QUO_W]};
      low_q[0] <= dvd_i[wspc_pkg::QUO_W-1:0];
      dsr_q[0] <= dsr_i;
      for (int k = 0; k < NST; k++) begin
        rem_q[k+1] <= rem_d[k];
        low_q[k+1] <= low_d[k];
        dsr_q[k+1] <= dsr_q[k];
      end
    end
  end

  assign quo_o = low_q[NST];

endmodule

`default_nettype wire
